FILE: rtl/core/sfd_pkg.sv
`timescale 1ns / 1ps
package sfd_pkg;

    // Memory geometry.
    localparam int MEM_BYTES    = 65536;
    localparam int PAGE_BYTES   = 256;
    localparam int SECTOR_BYTES = 4096;
    localparam int AW = $clog2(MEM_BYTES);
    localparam int PW = $clog2(PAGE_BYTES);
    localparam int SW = $clog2(SECTOR_BYTES);

    // Item operation codes.
    localparam logic [1:0] OP_XFER  = 2'd0;
    localparam logic [1:0] OP_DESEL = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Flash command codes.
    localparam logic [7:0] CMD_NONE = 8'h00;
    localparam logic [7:0] CMD_WRSR = 8'h01;
    localparam logic [7:0] CMD_PP   = 8'h02;
    localparam logic [7:0] CMD_READ = 8'h03;
    localparam logic [7:0] CMD_WRDI = 8'h04;
    localparam logic [7:0] CMD_RDSR = 8'h05;
    localparam logic [7:0] CMD_WREN = 8'h06;
    localparam logic [7:0] CMD_SE   = 8'h20;
    localparam logic [7:0] CMD_CE1  = 8'h60;
    localparam logic [7:0] CMD_RDID = 8'h9F;
    localparam logic [7:0] CMD_RES  = 8'hAB;
    localparam logic [7:0] CMD_DP   = 8'hB9;
    localparam logic [7:0] CMD_CE2  = 8'hC7;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ID_WORD  = 2'd0;
    localparam logic [1:0] CFG_PROG_TCK = 2'd1;
    localparam logic [1:0] CFG_ERAS_TCK = 2'd2;

    localparam logic [23:0] RST_ID_WORD  = 24'd15679510;
    localparam logic [15:0] RST_PROG_TCK = 16'd16;
    localparam logic [23:0] RST_ERAS_TCK = 24'd4096;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] mosi;
    } t_in_item;

    typedef struct packed {
        logic [7:0] miso;
        logic       busy_res;
    } t_out_item;

    typedef struct packed {
        logic clear_we;
        logic latch;
        logic mem_rd;
        logic commit;
    } t_ctl_cmd;

    typedef struct packed {
        logic clear_last;
        logic need_mem;
    } t_dp_stat;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_MEM
    } t_state;

endpackage

FILE: rtl/core/sfd_ctrl.sv
`timescale 1ns / 1ps
module sfd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  sfd_pkg::t_dp_stat i_stat,
    output sfd_pkg::t_ctl_cmd o_cmd
);
    import sfd_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_we = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = !r_out_valid || i_out_ready;
                if (i_in_valid && o_in_ready) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_stat.need_mem) begin
                    o_cmd.mem_rd = 1'b1;
                    n_state      = ST_MEM;
                end else begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_MEM: begin
                o_cmd.commit = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_mem_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_MEM |-> $past(r_state) == ST_EXEC)
        else $error("memory phase entered without execute phase");
    a_commit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> !r_out_valid)
        else $error("result committed while output register is full");
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CLEAR |-> !o_in_ready)
        else $error("item accepted during memory clear");
`endif
endmodule

FILE: rtl/core/sfd_dp.sv
`timescale 1ns / 1ps
module sfd_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sfd_pkg::t_in_item  i_item,
    input  sfd_pkg::t_ctl_cmd  i_cmd,
    output sfd_pkg::t_dp_stat  o_stat,
    output sfd_pkg::t_out_item o_out,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);
    import sfd_pkg::*;

    logic [7:0]  r_mem [MEM_BYTES];
    logic [7:0]  r_rd_data;
    logic [AW-1:0] r_clr_cnt;

    logic [23:0] r_id_word;
    logic [15:0] r_prog_tck;
    logic [23:0] r_eras_tck;

    t_in_item    r_item;
    t_out_item   r_out;

    logic [7:0]  r_status, n_status;
    logic [7:0]  r_command, n_command;
    logic [2:0]  r_fc, n_fc;
    logic [23:0] r_address, n_address;
    logic        r_pd, n_pd;
    logic [23:0] r_busy, n_busy;
    logic [AW-1:0] r_eptr, n_eptr;
    logic [AW:0] r_erem, n_erem;
    logic [7:0]  n_miso;

    logic          erase_we, prog_we, check_done;
    logic [AW-1:0] addr;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          wr_en;

    assign addr = r_address[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_word  <= RST_ID_WORD;
            r_prog_tck <= RST_PROG_TCK;
            r_eras_tck <= RST_ERAS_TCK;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ID_WORD:  r_id_word  <= i_cfg_data;
                CFG_PROG_TCK: r_prog_tck <= i_cfg_data[15:0];
                CFG_ERAS_TCK: r_eras_tck <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status  <= '0;
            r_command <= CMD_NONE;
            r_fc      <= '0;
            r_address <= '0;
            r_pd      <= 1'b0;
            r_busy    <= '0;
            r_eptr    <= '0;
            r_erem    <= '0;
            r_clr_cnt <= '0;
        end else begin
            if (i_cmd.clear_we) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cmd.commit) begin
                r_status  <= n_status;
                r_command <= n_command;
                r_fc      <= n_fc;
                r_address <= n_address;
                r_pd      <= n_pd;
                r_busy    <= n_busy;
                r_eptr    <= n_eptr;
                r_erem    <= n_erem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_item;
        end
        if (i_cmd.commit) begin
            r_out.miso     <= n_miso;
            r_out.busy_res <= n_status[0];
        end
    end

    always_comb begin
        n_status   = r_status;
        n_command  = r_command;
        n_fc       = r_fc;
        n_address  = r_address;
        n_pd       = r_pd;
        n_busy     = r_busy;
        n_eptr     = r_eptr;
        n_erem     = r_erem;
        n_miso     = 8'hFF;
        erase_we   = 1'b0;
        prog_we    = 1'b0;
        check_done = 1'b0;
        case (r_item.op)
            OP_XFER: begin
                if (r_fc != 3'd7) begin
                    n_fc = r_fc + 3'd1;
                end
                if (r_fc == 3'd0) begin
                    n_command = r_item.mosi;
                    if (r_status[0] && r_item.mosi != CMD_RDSR) begin
                        n_command = CMD_NONE;
                    end else if (r_pd && r_item.mosi != CMD_RES) begin
                        n_command = CMD_NONE;
                    end else if (!r_status[1] && (r_item.mosi == CMD_WRSR ||
                            r_item.mosi == CMD_PP || r_item.mosi == CMD_SE ||
                            r_item.mosi == CMD_CE2 || r_item.mosi == CMD_CE1)) begin
                        n_command = CMD_NONE;
                    end
                end else begin
                    case (r_command)
                        CMD_RDID: begin
                            case (r_fc)
                                3'd1: n_miso = r_id_word[23:16];
                                3'd2: n_miso = r_id_word[15:8];
                                3'd3: n_miso = r_id_word[7:0];
                                default: n_miso = 8'hFF;
                            endcase
                        end
                        CMD_RDSR: n_miso = r_status;
                        CMD_WRSR: begin
                            if (r_fc == 3'd1) begin
                                n_status = {r_item.mosi[7:2], r_status[1:0]};
                            end
                        end
                        CMD_READ, CMD_PP, CMD_SE: begin
                            if (r_fc <= 3'd3) begin
                                n_address = {r_address[15:0], r_item.mosi};
                            end else if (r_command == CMD_READ) begin
                                n_miso    = r_rd_data;
                                n_address = {{(24-AW){1'b0}}, addr + 1'b1};
                            end else if (r_command == CMD_PP) begin
                                prog_we   = 1'b1;
                                n_address = {{(24-AW){1'b0}}, addr[AW-1:PW],
                                             addr[PW-1:0] + 1'b1};
                            end
                        end
                        default: ;
                    endcase
                end
            end
            OP_DESEL: begin
                case (r_command)
                    CMD_WREN: if (r_fc == 3'd1) n_status[1] = 1'b1;
                    CMD_WRDI: if (r_fc == 3'd1) n_status[1] = 1'b0;
                    CMD_WRSR: if (r_fc >= 3'd2) n_status[1] = 1'b0;
                    CMD_PP: begin
                        if (r_fc >= 3'd5) begin
                            n_busy      = {8'd0, r_prog_tck};
                            n_status[0] = 1'b1;
                            check_done  = 1'b1;
                        end
                    end
                    CMD_SE: begin
                        if (r_fc == 3'd4) begin
                            n_eptr      = {addr[AW-1:SW], {SW{1'b0}}};
                            n_erem      = (AW+1)'(SECTOR_BYTES);
                            n_busy      = r_eras_tck;
                            n_status[0] = 1'b1;
                            check_done  = 1'b1;
                        end
                    end
                    CMD_CE1, CMD_CE2: begin
                        if (r_fc == 3'd1) begin
                            n_eptr      = '0;
                            n_erem      = (AW+1)'(MEM_BYTES);
                            n_busy      = r_eras_tck;
                            n_status[0] = 1'b1;
                            check_done  = 1'b1;
                        end
                    end
                    CMD_DP:  if (r_fc == 3'd1) n_pd = 1'b1;
                    CMD_RES: if (r_fc == 3'd1) n_pd = 1'b0;
                    default: ;
                endcase
                n_command = CMD_NONE;
                n_fc      = '0;
            end
            OP_TICK: begin
                if (r_erem != '0) begin
                    erase_we = 1'b1;
                    n_eptr   = r_eptr + 1'b1;
                    n_erem   = r_erem - 1'b1;
                end
                if (r_busy != '0) begin
                    n_busy = r_busy - 24'd1;
                end
                check_done = 1'b1;
            end
            default: ;
        endcase
        if (check_done && n_status[0] && n_busy == '0 && n_erem == '0) begin
            n_status[1:0] = 2'b00;
        end
    end

    // One write port shared by the clear sweep, erase ticks and page program.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_clr_cnt;
        wr_data = 8'hFF;
        if (i_cmd.clear_we) begin
            wr_en = 1'b1;
        end else if (i_cmd.commit && erase_we) begin
            wr_en   = 1'b1;
            wr_addr = r_eptr;
        end else if (i_cmd.commit && prog_we) begin
            wr_en   = 1'b1;
            wr_addr = addr;
            wr_data = r_rd_data & r_item.mosi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_rd_data <= r_mem[addr];
        end
    end

    assign o_stat.clear_last = &r_clr_cnt;
    assign o_stat.need_mem   = r_item.op == OP_XFER && r_fc >= 3'd4 &&
                               (r_command == CMD_READ || r_command == CMD_PP);
    assign o_out = r_out;

`ifndef ASSERT_OFF
    a_erase_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_erem != '0 |-> r_status[0])
        else $error("erase in progress without BUSY");
    a_erase_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_erem <= (AW+1)'(MEM_BYTES))
        else $error("erase length beyond memory size");
    a_busy_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_status[0] |-> r_busy == '0)
        else $error("busy timer running without BUSY");
`endif
endmodule

FILE: rtl/core/spi_nor_flash_device_top.sv
`timescale 1ns / 1ps
// SPI NOR flash device, one item per SPI byte exchange, deselect or time tick.
// Input channel: i_in_valid / o_in_ready with i_in_data (op, mosi). Output
// channel: o_out_valid / i_out_ready with o_out_data (miso, busy_res); every
// input transaction yields exactly one output transaction, in order.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// index 0 is the ID word, 1 the program tick count, 2 the erase tick count.
// Writes are always taken and should only be made while the block is idle.
// Flow: an accepted item is latched, then the execute phase loads the output
// register; read and program data bytes first go through the memory phase,
// which uses the registered memory read port. One item is worked on at a
// time, so no new item is taken until the current one has been committed.
// After reset the 65536-byte memory is swept to 0xFF, one byte per cycle,
// and o_in_ready stays low while the sweep runs.
// A one-entry output register holds the result; while the receiver stalls the
// block takes no new item until that register is emptied.
module spi_nor_flash_device_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sfd_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sfd_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);
    import sfd_pkg::*;

    t_ctl_cmd cmd;
    t_dp_stat stat;

    // Configuration registers take a write in any cycle.
    assign o_cfg_ready = 1'b1;

    sfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sfd_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_in_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out      (o_out_data),
        .i_cfg_we   (i_cfg_valid & o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

endmodule
